// ===== rtl/ndlt_pkg.sv =====
package ndlt_pkg;

   localparam int MAX_DIM = 4096;
   localparam int POS_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = POS_W + 1;
   localparam int SUM_W   = 2 * POS_W + 1;
   localparam int PIX_W   = 8;
   localparam int THR_W   = 8;
   localparam int FRAC_W  = 16;
   localparam int LUMA_W  = PIX_W + FRAC_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [FRAC_W-1:0] WEIGHT_BLUE  = FRAC_W'(7471);
   localparam logic [FRAC_W-1:0] WEIGHT_GREEN = FRAC_W'(38470);
   localparam logic [FRAC_W-1:0] WEIGHT_RED   = FRAC_W'(19595);

   localparam logic [DIM_W-1:0] RESET_SOURCE_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RESET_SOURCE_HEIGHT = DIM_W'(480);
   localparam logic [DIM_W-1:0] RESET_TILE_WIDTH    = DIM_W'(80);
   localparam logic [DIM_W-1:0] RESET_TILE_HEIGHT   = DIM_W'(60);
   localparam logic [THR_W-1:0] RESET_LUMA_THRESHOLD = THR_W'(127);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH   = 3'd0,
      CSR_SOURCE_HEIGHT  = 3'd1,
      CSR_TILE_WIDTH     = 3'd2,
      CSR_TILE_HEIGHT    = 3'd3,
      CSR_LUMA_THRESHOLD = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] src_w;
      logic [DIM_W-1:0] src_h;
      logic [DIM_W-1:0] tile_w;
      logic [DIM_W-1:0] tile_h;
   } dims_type;

   typedef struct packed {
      logic keep;
      logic row_end;
      logic frame_end;
   } pick_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      return r;
   endfunction

endpackage

// ===== rtl/ndlt_if.sv =====
interface ndlt_pix_if import ndlt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] blue;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] red;
   logic             frame_start;

   modport source (output valid, blue, green, red, frame_start, input ready);
   modport sink (input valid, blue, green, red, frame_start, output ready);
endinterface

interface ndlt_tile_if;
   logic valid;
   logic ready;
   logic tile_bit;
   logic row_end;
   logic frame_end;

   modport source (output valid, tile_bit, row_end, frame_end, input ready);
   modport sink (input valid, tile_bit, row_end, frame_end, output ready);
endinterface

interface ndlt_csr_if import ndlt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ndlt_position.sv =====
module ndlt_position import ndlt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     frame_start,
   input  dims_type dims,
   output pick_type pick
);

   logic [POS_W-1:0] src_col_ff, src_col_in, cur_src_col;
   logic [POS_W-1:0] src_row_ff, src_row_in, cur_src_row;
   logic [DIM_W-1:0] out_col_ff, out_col_in, cur_out_col;
   logic [DIM_W-1:0] out_row_ff, out_row_in, cur_out_row;
   logic [SUM_W-1:0] col_pick_ff, col_pick_in, cur_col_pick;
   logic [SUM_W-1:0] col_edge_ff, col_edge_in, cur_col_edge;
   logic [SUM_W-1:0] row_pick_ff, row_pick_in, cur_row_pick;
   logic [SUM_W-1:0] row_edge_ff, row_edge_in, cur_row_edge;
   logic [DIM_W-1:0] src_col_inc, src_row_inc, out_col_inc, out_row_inc;
   logic             row_sel;
   logic             keep;
   logic             last_in_row;

   always_comb begin
      if (frame_start) begin
         cur_src_col  = '0;
         cur_src_row  = '0;
         cur_out_col  = '0;
         cur_out_row  = '0;
         cur_col_pick = '0;
         cur_col_edge = SUM_W'(dims.tile_w);
         cur_row_pick = '0;
         cur_row_edge = SUM_W'(dims.tile_h);
      end else begin
         cur_src_col  = src_col_ff;
         cur_src_row  = src_row_ff;
         cur_out_col  = out_col_ff;
         cur_out_row  = out_row_ff;
         cur_col_pick = col_pick_ff;
         cur_col_edge = col_edge_ff;
         cur_row_pick = row_pick_ff;
         cur_row_edge = row_edge_ff;
      end
   end

   assign src_col_inc = {1'b0, cur_src_col} + DIM_W'(1);
   assign src_row_inc = {1'b0, cur_src_row} + DIM_W'(1);
   assign out_col_inc = cur_out_col + DIM_W'(1);
   assign out_row_inc = cur_out_row + DIM_W'(1);

   assign row_sel = (cur_out_row < dims.tile_h) && (cur_row_pick < cur_row_edge);
   assign keep = row_sel && (cur_out_col < dims.tile_w) && (cur_col_pick < cur_col_edge);
   assign last_in_row = (out_col_inc == dims.tile_w);

   assign pick.keep      = keep;
   assign pick.row_end   = last_in_row;
   assign pick.frame_end = last_in_row && (out_row_inc == dims.tile_h);

   always_comb begin
      src_col_in  = src_col_ff;
      src_row_in  = src_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      col_pick_in = col_pick_ff;
      col_edge_in = col_edge_ff;
      row_pick_in = row_pick_ff;
      row_edge_in = row_edge_ff;
      if (advance) begin
         out_row_in  = cur_out_row;
         row_pick_in = cur_row_pick;
         src_row_in  = cur_src_row;
         row_edge_in = cur_row_edge;
         if (src_col_inc < dims.src_w) begin
            src_col_in  = src_col_inc[POS_W-1:0];
            col_edge_in = cur_col_edge + SUM_W'(dims.tile_w);
            out_col_in  = keep ? out_col_inc : cur_out_col;
            col_pick_in = keep ? cur_col_pick + SUM_W'(dims.src_w) : cur_col_pick;
         end else begin
            src_col_in  = '0;
            out_col_in  = '0;
            col_pick_in = '0;
            col_edge_in = SUM_W'(dims.tile_w);
            if (row_sel) begin
               out_row_in  = out_row_inc;
               row_pick_in = cur_row_pick + SUM_W'(dims.src_h);
            end
            if (src_row_inc < dims.src_h) begin
               src_row_in  = src_row_inc[POS_W-1:0];
               row_edge_in = cur_row_edge + SUM_W'(dims.tile_h);
            end else begin
               src_row_in  = '0;
               out_row_in  = '0;
               row_pick_in = '0;
               row_edge_in = SUM_W'(dims.tile_h);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff  <= '0;
         src_row_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         col_pick_ff <= '0;
         col_edge_ff <= SUM_W'(RESET_TILE_WIDTH);
         row_pick_ff <= '0;
         row_edge_ff <= SUM_W'(RESET_TILE_HEIGHT);
      end else begin
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         col_pick_ff <= col_pick_in;
         col_edge_ff <= col_edge_in;
         row_pick_ff <= row_pick_in;
         row_edge_ff <= row_edge_in;
      end
   end

endmodule

// ===== rtl/ndlt_luma.sv =====
module ndlt_luma import ndlt_pkg::*; (
   input  logic [PIX_W-1:0] blue,
   input  logic [PIX_W-1:0] green,
   input  logic [PIX_W-1:0] red,
   input  logic [THR_W-1:0] threshold,
   output logic             bright
);

   logic [LUMA_W-1:0] luma;

   assign luma = LUMA_W'(WEIGHT_BLUE) * LUMA_W'(blue) + LUMA_W'(WEIGHT_GREEN) * LUMA_W'(green)
               + LUMA_W'(WEIGHT_RED) * LUMA_W'(red);
   assign bright = (luma >= {threshold, {FRAC_W{1'b0}}});

endmodule

// ===== rtl/nearest_downscale_luma_threshold.sv =====
// Channel   Direction  Words carried
// req_if    in         blue, green, red, frame_start (one source pixel)
// rsp_if    out        tile_bit, row_end, frame_end (one kept tile)
// csr_if    in         index, data (register write, always ready)
//
// One pixel word is taken every cycle unless rsp_if stalls; a kept pixel reaches rsp_if.
// The position counters decide on the word at the accept edge; the luminance weighting
// sits between the pixel register and the result register.
// Reset clears the position, the registers to their defaults and both valid flags.
// A stall on rsp_if holds the result and the pixel register, then backs up req_if.
module nearest_downscale_luma_threshold import ndlt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ndlt_pix_if.sink   req_if,
   ndlt_tile_if.source rsp_if,
   ndlt_csr_if.sink   csr_if
);

   logic [DIM_W-1:0] source_width_ff, source_height_ff, tile_width_ff, tile_height_ff;
   logic [THR_W-1:0] luma_threshold_ff;
   dims_type         dims;
   logic [DIM_W-1:0] clamp_tw, clamp_th;
   pick_type         pick;
   logic             req_acc;

   logic             pix_valid_ff, pix_valid_in;
   logic [PIX_W-1:0] pix_blue_ff, pix_green_ff, pix_red_ff;
   logic             pix_row_end_ff, pix_frame_end_ff;
   logic             pix_adv;
   logic             bright;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_bit_ff, rsp_row_end_ff, rsp_frame_end_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff   <= RESET_SOURCE_WIDTH;
         source_height_ff  <= RESET_SOURCE_HEIGHT;
         tile_width_ff     <= RESET_TILE_WIDTH;
         tile_height_ff    <= RESET_TILE_HEIGHT;
         luma_threshold_ff <= RESET_LUMA_THRESHOLD;
      end else if (csr_if.valid) begin
         case (csr_index_type'(csr_if.index))
            CSR_SOURCE_WIDTH:   source_width_ff   <= csr_if.data;
            CSR_SOURCE_HEIGHT:  source_height_ff  <= csr_if.data;
            CSR_TILE_WIDTH:     tile_width_ff     <= csr_if.data;
            CSR_TILE_HEIGHT:    tile_height_ff    <= csr_if.data;
            CSR_LUMA_THRESHOLD: luma_threshold_ff <= csr_if.data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      dims.src_w  = clamp_dim(source_width_ff);
      dims.src_h  = clamp_dim(source_height_ff);
      clamp_tw    = clamp_dim(tile_width_ff);
      clamp_th    = clamp_dim(tile_height_ff);
      dims.tile_w = (clamp_tw > dims.src_w) ? dims.src_w : clamp_tw;
      dims.tile_h = (clamp_th > dims.src_h) ? dims.src_h : clamp_th;
   end

   assign pix_adv      = pix_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !pix_valid_ff || pix_adv;
   assign req_acc      = req_if.valid && req_if.ready;

   ndlt_position u_position (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_acc),
      .frame_start (req_if.frame_start),
      .dims        (dims),
      .pick        (pick)
   );

   always_comb begin
      pix_valid_in = pix_valid_ff;
      if (req_acc) pix_valid_in = pick.keep;
      else if (pix_adv) pix_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) pix_valid_ff <= 1'b0;
      else pix_valid_ff <= pix_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         pix_blue_ff      <= req_if.blue;
         pix_green_ff     <= req_if.green;
         pix_red_ff       <= req_if.red;
         pix_row_end_ff   <= pick.row_end;
         pix_frame_end_ff <= pick.frame_end;
      end
   end

   ndlt_luma u_luma (
      .blue      (pix_blue_ff),
      .green     (pix_green_ff),
      .red       (pix_red_ff),
      .threshold (luma_threshold_ff),
      .bright    (bright)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pix_adv) rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (pix_adv) begin
         rsp_bit_ff       <= bright;
         rsp_row_end_ff   <= pix_row_end_ff;
         rsp_frame_end_ff <= pix_frame_end_ff;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.tile_bit  = rsp_bit_ff;
   assign rsp_if.row_end   = rsp_row_end_ff;
   assign rsp_if.frame_end = rsp_frame_end_ff;

endmodule

// ===== rtl/ndlt_checker.sv =====
module ndlt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_tile_bit,
   input logic rsp_row_end,
   input logic rsp_frame_end
);

   logic req_acc;

   assign req_acc = req_valid && req_ready;

   // A word that waits on the result side keeps its value until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tile_bit)
         && $stable(rsp_row_end) && $stable(rsp_frame_end))
      else $error("result word changed while stalled");

   // The last tile of the frame is always the last tile of a row.
   a_frame_end_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_frame_end || rsp_row_end)
      else $error("frame end without row end");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A result appearing on an empty output follows an accepted pixel via the pixel register.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(reset, 2) && $rose(rsp_valid) |-> $past(req_acc, 2))
      else $error("result without a matching pixel");

endmodule

bind nearest_downscale_luma_threshold ndlt_checker u_ndlt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_tile_bit  (rsp_if.tile_bit),
   .rsp_row_end   (rsp_if.row_end),
   .rsp_frame_end (rsp_if.frame_end)
);
